[rtl/pet_pkg.sv]
package pet_pkg;

  localparam logic [2:0] FN_FILL   = 3'd0;
  localparam logic [2:0] FN_SENT   = 3'd1;
  localparam logic [2:0] FN_OFILL  = 3'd2;
  localparam logic [2:0] FN_CLOSE  = 3'd3;
  localparam logic [2:0] FN_MODIFY = 3'd4;
  localparam logic [2:0] FN_QUERY  = 3'd5;

  localparam int unsigned SYM_W = 10;
  localparam int unsigned QTY_W = 32;
  localparam int unsigned ID_W  = 32;
  localparam int unsigned SUM_W = 64;

  // one symbol row of the position store
  typedef struct packed {
    logic [SUM_W-1:0] bought;
    logic [SUM_W-1:0] sold;
    logic [SUM_W-1:0] buy_val;
    logic [SUM_W-1:0] sell_val;
    logic [SUM_W-1:0] net;
    logic [SUM_W-1:0] out_buy;
    logic [SUM_W-1:0] out_sell;
  } sym_rec_t;

  // one tracked order
  typedef struct packed {
    logic [ID_W-1:0]  key;
    logic [SYM_W-1:0] sym;
    logic             side;
    logic [QTY_W-1:0] rem;
  } ord_ent_t;

  // what the row update has to apply
  typedef struct packed {
    logic             fill_en;
    logic             fill_side;
    logic [QTY_W-1:0] fill_qty;
    logic [SUM_W-1:0] fill_prod;
    logic             take_en;
    logic             take_side;
    logic [QTY_W-1:0] take_amt;
    logic             add_en;
    logic             add_side;
    logic [QTY_W-1:0] add_amt;
  } upd_ctrl_t;

endpackage

[rtl/position_exposure_tracker.sv]
// Position and exposure tracker: one event beat in, one result beat out. Per-symbol
// totals live in one SYMBOLS-deep RAM (read, update, write back), orders in an
// ORDER_SLOTS-deep RAM searched linearly for the order id. After reset the symbol RAM
// is zeroed before the first beat is taken. A fill or query goes through symbol read,
// row update and result; an order event first adds a table scan of one slot per
// cycle, stopping at the first matching id or at the last slot. The next event is taken
// while a result waits on the master side.
module position_exposure_tracker #(
  parameter int unsigned SYMBOLS     = 1024,
  parameter int unsigned ORDER_SLOTS = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // order_id[31:0], symbol[41:32], side[42], qty[74:43], price[106:75]
  input  logic [111:0] s_axis_tdata_i,
  // func[2:0]
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // net_pos, outstanding_buy, outstanding_sell, buy_exposure, sell_exposure,
  // bought_total, sold_total, buy_value, sell_value; 64 bits each from bit 0 up
  output logic [575:0] m_axis_tdata_o,
  // order_found[0], table_full[1]
  output logic [1:0]   m_axis_tuser_o
);
  import pet_pkg::*;

  localparam int unsigned SAW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned OAW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int unsigned SRW = $bits(sym_rec_t);
  localparam int unsigned ORW = $bits(ord_ent_t);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_SRD  = 3'd3;
  localparam logic [2:0] ST_SMOD = 3'd4;
  localparam logic [2:0] ST_SRES = 3'd5;

  function automatic logic [SYM_W-1:0] sym_wrap(input logic [SYM_W-1:0] v);
    logic [SYM_W+17:0] r;
    logic [SYM_W+17:0] s;
    r = (SYM_W+18)'(v);
    for (int k = SYM_W - 1; k >= 0; k--) begin
      s = (SYM_W+18)'(SYMBOLS) << k;
      if (r >= s) begin
        r = r - s;
      end
    end
    return r[SYM_W-1:0];
  endfunction

  logic [2:0] state_q, state_d;
  logic [SAW-1:0] clr_q, clr_d;
  logic [OAW:0] cnt_q, cnt_d;
  logic cmp_pend_q, cmp_pend_d;
  logic [OAW-1:0] cmp_idx_q, cmp_idx_d;
  logic free_found_q, free_found_d;
  logic [OAW-1:0] free_idx_q, free_idx_d;
  logic [ORDER_SLOTS-1:0] valid_q, valid_d;

  logic [2:0] func_q;
  logic [ID_W-1:0] id_q;
  logic [SYM_W-1:0] sym_q;
  logic side_q;
  logic [QTY_W-1:0] qty_q, price_q;
  logic [SUM_W-1:0] prod_q;
  logic hit_q, full_q;
  logic [OAW-1:0] slot_q;
  ord_ent_t ent_q;
  sym_rec_t rec_q;

  logic out_valid_q;
  logic [575:0] out_data_q;
  logic [1:0] out_user_q;

  logic in_acc, issue, hit, cur_free, ord_evt;
  logic sym_we, sym_re, ord_we, ord_re;
  logic [SAW-1:0] sym_waddr;
  logic [SRW-1:0] sym_wdata, sym_rdata;
  ord_ent_t ord_wdata, ord_rdata_s;
  logic [ORW-1:0] ord_rdata;
  upd_ctrl_t ctl;
  sym_rec_t rec_new;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign issue = cnt_q < (OAW+1)'(ORDER_SLOTS);
  assign ord_rdata_s = ord_ent_t'(ord_rdata);
  assign hit = cmp_pend_q && valid_q[cmp_idx_q] && (ord_rdata_s.key == id_q);
  assign cur_free = cmp_pend_q && !valid_q[cmp_idx_q];
  assign ord_evt = (func_q == FN_OFILL) || (func_q == FN_CLOSE) || (func_q == FN_MODIFY);

  pet_ram #(.WIDTH(SRW), .DEPTH(SYMBOLS)) u_sym_ram (
    .clk_i  (clk_i),
    .we_i   (sym_we),
    .waddr_i(sym_waddr),
    .wdata_i(sym_wdata),
    .re_i   (sym_re),
    .raddr_i(SAW'(sym_q)),
    .rdata_o(sym_rdata)
  );

  pet_ram #(.WIDTH(ORW), .DEPTH(ORDER_SLOTS)) u_ord_ram (
    .clk_i  (clk_i),
    .we_i   (ord_we),
    .waddr_i(slot_q),
    .wdata_i(ord_wdata),
    .re_i   (ord_re),
    .raddr_i(cnt_q[OAW-1:0]),
    .rdata_o(ord_rdata)
  );

  pet_sym_update u_upd (
    .rec_i(sym_rec_t'(sym_rdata)),
    .ctl_i(ctl),
    .rec_o(rec_new)
  );

  // row update controls
  always_comb begin
    ctl           = '0;
    ctl.fill_en   = (func_q == FN_FILL);
    ctl.fill_side = side_q;
    ctl.fill_qty  = qty_q;
    ctl.fill_prod = prod_q;
    ctl.take_side = ent_q.side;
    ctl.add_side  = side_q;
    ctl.add_amt   = qty_q;
    ctl.take_amt  = (func_q == FN_OFILL) ? qty_q : ent_q.rem;
    ctl.take_en   = ord_evt && hit_q;
    ctl.add_en    = (func_q == FN_SENT) || ((func_q == FN_MODIFY) && hit_q);
  end

  // memory port control
  always_comb begin
    sym_we    = 1'b0;
    sym_waddr = SAW'(sym_q);
    sym_wdata = SRW'(rec_new);
    sym_re    = (state_q == ST_SRD);
    ord_re    = (state_q == ST_SCAN) && issue;
    ord_we    = 1'b0;
    ord_wdata = ent_q;
    valid_d   = valid_q;
    if (state_q == ST_CLR) begin
      sym_we    = 1'b1;
      sym_waddr = clr_q;
      sym_wdata = '0;
    end
    if (state_q == ST_SMOD) begin
      sym_we = 1'b1;
      unique case (func_q)
        FN_SENT: begin
          if (!full_q) begin
            ord_we          = 1'b1;
            ord_wdata.key   = id_q;
            ord_wdata.sym   = sym_q;
            ord_wdata.side  = side_q;
            ord_wdata.rem   = qty_q;
            valid_d[slot_q] = 1'b1;
          end
        end
        FN_OFILL: begin
          if (hit_q) begin
            if (qty_q >= ent_q.rem) begin
              valid_d[slot_q] = 1'b0;
            end else begin
              ord_we        = 1'b1;
              ord_wdata.rem = ent_q.rem - qty_q;
            end
          end
        end
        FN_CLOSE: begin
          if (hit_q) begin
            valid_d[slot_q] = 1'b0;
          end
        end
        FN_MODIFY: begin
          if (hit_q) begin
            ord_we         = 1'b1;
            ord_wdata.side = side_q;
            ord_wdata.rem  = qty_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    cmp_pend_d   = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    unique case (state_q)
      ST_CLR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == SAW'(SYMBOLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_d        = '0;
        free_found_d = 1'b0;
        if (in_acc) begin
          priority if (s_axis_tuser_i == FN_FILL) begin
            state_d = ST_SRD;
          end else if (s_axis_tuser_i >= FN_SENT && s_axis_tuser_i <= FN_MODIFY) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_SRD;
          end
        end
      end
      ST_SCAN: begin
        if (cur_free && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = cmp_idx_q;
        end
        if (hit || (cmp_pend_q && cmp_idx_q == OAW'(ORDER_SLOTS - 1))) begin
          state_d = ST_SRD;
        end else begin
          cnt_d      = cnt_q + 1'b1;
          cmp_pend_d = issue;
          cmp_idx_d  = cnt_q[OAW-1:0];
        end
      end
      ST_SRD:  state_d = ST_SMOD;
      ST_SMOD: state_d = ST_SRES;
      ST_SRES: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      clr_q        <= '0;
      cnt_q        <= '0;
      cmp_pend_q   <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      cnt_q        <= cnt_d;
      cmp_pend_q   <= cmp_pend_d;
      free_found_q <= free_found_d;
      valid_q      <= valid_d;
      if (state_q == ST_SRES && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    free_idx_q <= free_idx_d;
    if (in_acc) begin
      func_q  <= s_axis_tuser_i;
      id_q    <= s_axis_tdata_i[31:0];
      sym_q   <= sym_wrap(s_axis_tdata_i[41:32]);
      side_q  <= s_axis_tdata_i[42];
      qty_q   <= s_axis_tdata_i[74:43];
      price_q <= s_axis_tdata_i[106:75];
      hit_q   <= 1'b0;
      full_q  <= 1'b0;
    end
    if (state_q == ST_SCAN) begin
      if (hit) begin
        hit_q  <= 1'b1;
        slot_q <= cmp_idx_q;
        ent_q  <= ord_rdata_s;
        if (ord_evt) begin
          sym_q <= ord_rdata_s.sym;
        end
      end else if (cmp_pend_q && cmp_idx_q == OAW'(ORDER_SLOTS - 1)) begin
        full_q <= !(free_found_q || cur_free);
        slot_q <= free_found_q ? free_idx_q : cmp_idx_q;
      end
    end
    if (state_q == ST_SRD) begin
      prod_q <= SUM_W'(qty_q) * SUM_W'(price_q);
    end
    if (state_q == ST_SMOD) begin
      rec_q <= rec_new;
    end
    if (state_q == ST_SRES && state_d == ST_IDLE) begin
      out_data_q <= {rec_q.sell_val, rec_q.buy_val, rec_q.sold, rec_q.bought,
                     rec_q.out_sell - rec_q.net, rec_q.net + rec_q.out_buy,
                     rec_q.out_sell, rec_q.out_buy, rec_q.net};
      out_user_q <= {(func_q == FN_SENT) && full_q, ord_evt && hit_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  a_no_sym_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !sym_we)
    else $error("symbol store written during order scan");

  a_smod_to_sres: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SMOD) |=> (state_q == ST_SRES))
    else $error("row update not followed by result stage");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= (OAW+1)'(ORDER_SLOTS)))
    else $error("order scan ran past the table");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_user_q[0] && out_user_q[1]))
    else $error("order_found and table_full both set");

endmodule

[rtl/pet_ram.sv]
module pet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/pet_sym_update.sv]
module pet_sym_update (
  input  pet_pkg::sym_rec_t  rec_i,
  input  pet_pkg::upd_ctrl_t ctl_i,
  output pet_pkg::sym_rec_t  rec_o
);
  import pet_pkg::*;

  logic [SUM_W-1:0] take_w;
  logic [SUM_W-1:0] add_w;
  logic [SUM_W-1:0] fq_w;
  logic [SUM_W-1:0] ob_t;
  logic [SUM_W-1:0] os_t;

  assign take_w = SUM_W'(ctl_i.take_amt);
  assign add_w  = SUM_W'(ctl_i.add_amt);
  assign fq_w   = SUM_W'(ctl_i.fill_qty);

  // decrease saturates at zero
  always_comb begin
    ob_t = rec_i.out_buy;
    os_t = rec_i.out_sell;
    if (ctl_i.take_en && !ctl_i.take_side) begin
      ob_t = (take_w < ob_t) ? ob_t - take_w : '0;
    end
    if (ctl_i.take_en && ctl_i.take_side) begin
      os_t = (take_w < os_t) ? os_t - take_w : '0;
    end
  end

  always_comb begin
    rec_o          = rec_i;
    rec_o.out_buy  = (ctl_i.add_en && !ctl_i.add_side) ? ob_t + add_w : ob_t;
    rec_o.out_sell = (ctl_i.add_en && ctl_i.add_side) ? os_t + add_w : os_t;
    if (ctl_i.fill_en) begin
      if (!ctl_i.fill_side) begin
        rec_o.bought  = rec_i.bought + fq_w;
        rec_o.buy_val = rec_i.buy_val + ctl_i.fill_prod;
        rec_o.net     = rec_i.net + fq_w;
      end else begin
        rec_o.sold     = rec_i.sold + fq_w;
        rec_o.sell_val = rec_i.sell_val + ctl_i.fill_prod;
        rec_o.net      = rec_i.net - fq_w;
      end
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import pet_pkg::*;

  localparam int unsigned NSYM   = 1024;
  localparam int unsigned NSLOT  = 256;
  localparam int unsigned TAIL   = 600;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] order_id;
    logic [9:0]  symbol;
    logic        side;
    logic [31:0] qty;
    logic [31:0] price;
  } event_t;

  typedef struct packed {
    logic [63:0] net_pos;
    logic [63:0] outstanding_buy;
    logic [63:0] outstanding_sell;
    logic [63:0] buy_exposure;
    logic [63:0] sell_exposure;
    logic [63:0] bought_total;
    logic [63:0] sold_total;
    logic [63:0] buy_value;
    logic [63:0] sell_value;
    logic        order_found;
    logic        table_full;
  } snapshot_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [111:0] s_axis_tdata_i = '0;
  logic [2:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [575:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  always #5 clk_i = ~clk_i;

  position_exposure_tracker dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  // shadow position book
  logic [63:0] bk_bought [NSYM];
  logic [63:0] bk_sold   [NSYM];
  logic [63:0] bk_bval   [NSYM];
  logic [63:0] bk_sval   [NSYM];
  logic [63:0] bk_net    [NSYM];
  logic [63:0] bk_obuy   [NSYM];
  logic [63:0] bk_osell  [NSYM];
  logic        ob_valid  [NSLOT];
  logic [31:0] ob_key    [NSLOT];
  logic [9:0]  ob_sym    [NSLOT];
  logic        ob_side   [NSLOT];
  logic [31:0] ob_rem    [NSLOT];

  snapshot_t   pending_snaps[$];
  int          errors = 0;
  int          sent_cnt = 0;
  int          checked_cnt = 0;
  int          full_cnt = 0;
  int          found_cnt = 0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  longint unsigned cycles = 0;
  logic [31:0] live_ids[$];

  function automatic int lookup_order(logic [31:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (ob_valid[i] && ob_key[i] == id) return i;
    return -1;
  endfunction

  function automatic void release_out(int s, logic sd, logic [63:0] amt);
    if (sd) bk_osell[s] -= (amt < bk_osell[s]) ? amt : bk_osell[s];
    else    bk_obuy[s]  -= (amt < bk_obuy[s])  ? amt : bk_obuy[s];
  endfunction

  function automatic void reserve_out(int s, logic sd, logic [63:0] amt);
    if (sd) bk_osell[s] += amt;
    else    bk_obuy[s]  += amt;
  endfunction

  function automatic snapshot_t apply_event(event_t ev);
    snapshot_t r;
    int s;
    int k;
    logic [63:0] prod;
    s = ev.symbol;
    r = '0;
    prod = 64'(ev.qty) * 64'(ev.price);
    if (ev.func == FN_FILL) begin
      if (!ev.side) begin
        bk_bought[s] += 64'(ev.qty);
        bk_bval[s] += prod;
        bk_net[s] += 64'(ev.qty);
      end else begin
        bk_sold[s] += 64'(ev.qty);
        bk_sval[s] += prod;
        bk_net[s] -= 64'(ev.qty);
      end
    end else if (ev.func == FN_SENT) begin
      reserve_out(s, ev.side, 64'(ev.qty));
      k = lookup_order(ev.order_id);
      if (k < 0)
        for (int i = 0; i < NSLOT; i++)
          if (!ob_valid[i]) begin
            k = i;
            break;
          end
      if (k < 0) r.table_full = 1'b1;
      else begin
        ob_valid[k] = 1'b1;
        ob_key[k] = ev.order_id;
        ob_sym[k] = ev.symbol;
        ob_side[k] = ev.side;
        ob_rem[k] = ev.qty;
      end
    end else if (ev.func == FN_OFILL || ev.func == FN_CLOSE || ev.func == FN_MODIFY) begin
      k = lookup_order(ev.order_id);
      if (k >= 0) begin
        r.order_found = 1'b1;
        s = ob_sym[k];
        if (ev.func == FN_OFILL) begin
          release_out(s, ob_side[k], 64'(ev.qty));
          if (ev.qty >= ob_rem[k]) ob_valid[k] = 1'b0;
          else ob_rem[k] -= ev.qty;
        end else if (ev.func == FN_CLOSE) begin
          release_out(s, ob_side[k], 64'(ob_rem[k]));
          ob_valid[k] = 1'b0;
        end else begin
          release_out(s, ob_side[k], 64'(ob_rem[k]));
          reserve_out(s, ev.side, 64'(ev.qty));
          ob_side[k] = ev.side;
          ob_rem[k] = ev.qty;
        end
      end
    end
    r.net_pos = bk_net[s];
    r.outstanding_buy = bk_obuy[s];
    r.outstanding_sell = bk_osell[s];
    r.buy_exposure = bk_net[s] + bk_obuy[s];
    r.sell_exposure = (64'd0 - bk_net[s]) + bk_osell[s];
    r.bought_total = bk_bought[s];
    r.sold_total = bk_sold[s];
    r.buy_value = bk_bval[s];
    r.sell_value = bk_sval[s];
    return r;
  endfunction

  // one event beat, with optional leading idle cycles
  task automatic send_event(event_t ev);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= ev.func;
    s_axis_tdata_i <= {5'd0, ev.price, ev.qty, ev.side, ev.symbol, ev.order_id};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_snaps.push_back(apply_event(ev));
    if (ev.func == FN_SENT) live_ids.push_back(ev.order_id);
    sent_cnt++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni) m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    snapshot_t got;
    snapshot_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[63:0], m_axis_tdata_o[127:64], m_axis_tdata_o[191:128],
             m_axis_tdata_o[255:192], m_axis_tdata_o[319:256], m_axis_tdata_o[383:320],
             m_axis_tdata_o[447:384], m_axis_tdata_o[511:448], m_axis_tdata_o[575:512],
             m_axis_tuser_o[0], m_axis_tuser_o[1]};
      if (pending_snaps.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = pending_snaps.pop_front();
        checked_cnt++;
        if (got.table_full) full_cnt++;
        if (got.order_found) found_cnt++;
        if (got !== want) begin
          errors++;
          if (got.net_pos !== want.net_pos)
            $display("%0t: net_pos exp %h got %h", $time, want.net_pos, got.net_pos);
          if (got.outstanding_buy !== want.outstanding_buy)
            $display("%0t: outstanding_buy exp %h got %h", $time, want.outstanding_buy,
                     got.outstanding_buy);
          if (got.outstanding_sell !== want.outstanding_sell)
            $display("%0t: outstanding_sell exp %h got %h", $time, want.outstanding_sell,
                     got.outstanding_sell);
          if (got.buy_exposure !== want.buy_exposure)
            $display("%0t: buy_exposure exp %h got %h", $time, want.buy_exposure,
                     got.buy_exposure);
          if (got.sell_exposure !== want.sell_exposure)
            $display("%0t: sell_exposure exp %h got %h", $time, want.sell_exposure,
                     got.sell_exposure);
          if (got.bought_total !== want.bought_total)
            $display("%0t: bought_total exp %h got %h", $time, want.bought_total,
                     got.bought_total);
          if (got.sold_total !== want.sold_total)
            $display("%0t: sold_total exp %h got %h", $time, want.sold_total, got.sold_total);
          if (got.buy_value !== want.buy_value)
            $display("%0t: buy_value exp %h got %h", $time, want.buy_value, got.buy_value);
          if (got.sell_value !== want.sell_value)
            $display("%0t: sell_value exp %h got %h", $time, want.sell_value, got.sell_value);
          if (got.order_found !== want.order_found)
            $display("%0t: order_found exp %b got %b", $time, want.order_found, got.order_found);
          if (got.table_full !== want.table_full)
            $display("%0t: table_full exp %b got %b", $time, want.table_full, got.table_full);
        end
      end
    end
  end

  function automatic event_t mk(logic [2:0] f, logic [31:0] id, logic [9:0] sym, logic sd,
                                logic [31:0] q, logic [31:0] p);
    event_t ev;
    ev.func = f;
    ev.order_id = id;
    ev.symbol = sym;
    ev.side = sd;
    ev.qty = q;
    ev.price = p;
    return ev;
  endfunction

  // symbols mostly from a small hot set so positions accumulate
  function automatic logic [9:0] pick_symbol();
    return ($urandom_range(9) < 8) ? 10'($urandom_range(7)) : 10'($urandom);
  endfunction

  function automatic logic [31:0] pick_qty();
    case ($urandom_range(3))
      0: return 32'($urandom_range(100));
      1: return 32'hFFFF_FFFF - 32'($urandom_range(3));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_known_id();
    if (live_ids.size() == 0 || $urandom_range(9) == 0) return 32'($urandom);
    return live_ids[$urandom_range(live_ids.size() - 1)];
  endfunction

  task automatic test_directed();
    send_event(mk(FN_QUERY, 32'd0, 10'd0, 1'b0, 32'd0, 32'd0));
    send_event(mk(FN_FILL, 32'hFFFF_FFFF, 10'd1023, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_event(mk(FN_FILL, 32'd0, 10'd1023, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_event(mk(FN_FILL, 32'd0, 10'd0, 1'b1, 32'd5, 32'd0));
    send_event(mk(FN_SENT, 32'h0000_0001, 10'd3, 1'b0, 32'd100, 32'hFFFF_FFFF));
    send_event(mk(FN_SENT, 32'hFFFF_FFFF, 10'd3, 1'b1, 32'd50, 32'd0));
    send_event(mk(FN_OFILL, 32'h0000_0001, 10'd9, 1'b1, 32'd30, 32'd0));
    send_event(mk(FN_OFILL, 32'h0000_0001, 10'd9, 1'b0, 32'd70, 32'd0));
    send_event(mk(FN_OFILL, 32'h0000_0001, 10'd9, 1'b0, 32'd1, 32'd0));
    send_event(mk(FN_MODIFY, 32'hFFFF_FFFF, 10'd0, 1'b0, 32'hFFFF_FFFF, 32'd0));
    send_event(mk(FN_SENT, 32'hFFFF_FFFF, 10'd4, 1'b1, 32'd7, 32'd0));
    send_event(mk(FN_OFILL, 32'hFFFF_FFFF, 10'd0, 1'b0, 32'hFFFF_FFFF, 32'd0));
    send_event(mk(FN_CLOSE, 32'd12345, 10'd5, 1'b0, 32'd0, 32'd0));
    send_event(mk(FN_SENT, 32'd77, 10'd5, 1'b0, 32'd40, 32'd0));
    send_event(mk(FN_CLOSE, 32'd77, 10'd0, 1'b1, 32'd0, 32'd0));
    send_event(mk(3'd6, 32'd0, 10'd1023, 1'b1, 32'd0, 32'd0));
    send_event(mk(3'd7, 32'd0, 10'd3, 1'b0, 32'd0, 32'd0));
    send_event(mk(FN_QUERY, 32'd0, 10'd3, 1'b1, 32'd0, 32'd0));
  endtask

  // overflow the order table, then drain it again
  task automatic test_table_full();
    for (int i = 0; i < NSLOT + 4; i++)
      send_event(mk(FN_SENT, 32'h1000_0000 + i, 10'(i % 8), i[0], 32'(i + 1), 32'd0));
    send_event(mk(FN_SENT, 32'h1000_0005, 10'd6, 1'b1, 32'd9, 32'd0));
    for (int i = 0; i < NSLOT + 4; i++)
      send_event(mk(FN_CLOSE, 32'h1000_0000 + i, 10'd0, 1'b0, 32'd0, 32'd0));
    live_ids.delete();
  endtask

  task automatic test_random(int count);
    event_t ev;
    for (int n = 0; n < count; n++) begin
      ev.order_id = 32'($urandom);
      ev.symbol = pick_symbol();
      ev.side = 1'($urandom);
      ev.qty = pick_qty();
      ev.price = 32'($urandom);
      case ($urandom_range(19))
        0, 1, 2, 3: ev.func = FN_FILL;
        4, 5, 6, 7, 8: ev.func = FN_SENT;
        9, 10, 11, 12: ev.func = FN_OFILL;
        13, 14: ev.func = FN_CLOSE;
        15, 16: ev.func = FN_MODIFY;
        17: ev.func = FN_QUERY;
        default: ev.func = 3'($urandom_range(7));
      endcase
      if (ev.func == FN_SENT && $urandom_range(3) == 0) ev.order_id = pick_known_id();
      if (ev.func inside {FN_OFILL, FN_CLOSE, FN_MODIFY}) ev.order_id = pick_known_id();
      // small fill quantities make partial fills common
      if (ev.func == FN_OFILL && $urandom_range(1) == 0) ev.qty = 32'($urandom_range(60));
      send_event(ev);
      if (live_ids.size() > 400) live_ids = live_ids[200:$];
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < NSYM; i++) begin
      bk_bought[i] = '0; bk_sold[i] = '0; bk_bval[i] = '0; bk_sval[i] = '0;
      bk_net[i] = '0; bk_obuy[i] = '0; bk_osell[i] = '0;
    end
    for (int i = 0; i < NSLOT; i++) ob_valid[i] = 1'b0;

    src_idle_pct = 20; snk_idle_pct = 66;
    test_directed();
    test_random(330);
    src_idle_pct = 66; snk_idle_pct = 20;
    test_table_full();
    test_random(330);
    src_idle_pct = 0; snk_idle_pct = 0;
    test_random(300);
    s_axis_tvalid_i <= 1'b0;

    while (pending_snaps.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    $display("covered %0d events, %0d results checked (%0d matched orders, %0d table full)",
             sent_cnt, checked_cnt, found_cnt, full_cnt);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
